// ===== rtl/core/cbbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbbr_pkg
// Shared types, constants and credit helpers of the batch reorderer.
// ----------------------------------------------------------------------------
package cbbr_pkg;

    // stack depth default
    localparam int unsigned MAX_BATCH_DEF = 64;

    // field widths
    localparam int unsigned TAG_W     = 32;
    localparam int unsigned SIZE_W    = 32;
    localparam int unsigned LSIZE_W   = 13;
    localparam int unsigned LCRED_W   = 2;
    localparam int unsigned HCRED_W   = 7;
    localparam int unsigned SUM_W     = 14;
    localparam int unsigned RUN_W     = 24;
    localparam int unsigned BATCH_W   = 7;
    localparam int unsigned KIND_W    = 2;

    localparam int unsigned LIGHT_W = TAG_W + LSIZE_W + LCRED_W;
    localparam int unsigned HEAVY_W = TAG_W + SIZE_W + HCRED_W;

    // divider: |credit_sum| * 256 needs 22 bits
    localparam int unsigned DIV_NUM_W  = SUM_W + 8;
    localparam int unsigned DIV_STEPS  = DIV_NUM_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    // register reset and map
    localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd64;
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_BATCH_SIZE = 1'b0;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_OK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP_OK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_NONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PUSH_OVF = 2'd3;

    // heavy credit by highest set bit of the size
    localparam logic [HCRED_W-1:0] HEAVY_CREDIT [32] = '{
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd4,  7'd8,
        7'd8,  7'd8,  7'd16, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
        7'd55, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60, 7'd0
    };

    // request to the correction divider
    typedef struct packed {
        logic                      start;
        logic signed [SUM_W-1:0]   credit_sum;
        logic [BATCH_W-1:0]        divisor;
    } t_div_req;

    function automatic logic [4:0] top_bit(input logic [SIZE_W-1:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) idx = 5'(i);
        end
        return idx;
    endfunction

    function automatic logic [HCRED_W-1:0] heavy_credit(input logic [SIZE_W-1:0] v);
        return HEAVY_CREDIT[top_bit(v)];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cbbr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbbr_div
// Restoring divider for the batch correction: -credit_sum * 256 / divisor,
// truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbbr_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire cbbr_pkg::t_div_req                    i_req,
    output logic                                       o_done,
    output logic signed [cbbr_pkg::RUN_W-1:0]          o_quot
);

    localparam int unsigned NW = cbbr_pkg::DIV_NUM_W;
    localparam int unsigned BW = cbbr_pkg::BATCH_W;

    logic                              r_busy;
    logic                              r_done;
    logic [cbbr_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [NW-1:0]                     r_num;
    logic [NW-1:0]                     r_quot;
    logic [BW-1:0]                     r_rem;
    logic [BW-1:0]                     r_div;
    logic                              r_neg;

    logic [cbbr_pkg::SUM_W-1:0]        w_mag;
    logic [BW:0]                       w_rem_sh;
    logic                              w_fit;
    logic [BW:0]                       w_rem_sub;
    logic [cbbr_pkg::RUN_W-1:0]        w_q_ext;

    // magnitude of the credit sum; quotient is negative when the sum is positive
    assign w_mag = i_req.credit_sum[cbbr_pkg::SUM_W-1]
                 ? (cbbr_pkg::SUM_W)'(-i_req.credit_sum) : i_req.credit_sum;

    // one restoring step
    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_fit     = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == (cbbr_pkg::DIV_CNT_W)'(cbbr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {w_mag, 8'd0};
            r_quot <= '0;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_neg  <= (i_req.credit_sum > 0);
        end else if (r_busy) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_quot <= {r_quot[NW-2:0], w_fit};
            r_rem  <= w_fit ? w_rem_sub[BW-1:0] : w_rem_sh[BW-1:0];
        end
    end

    assign w_q_ext = (cbbr_pkg::RUN_W)'(r_quot);
    assign o_quot  = r_neg ? $signed(-w_q_ext) : $signed(w_q_ext);
    assign o_done  = r_done;

endmodule
`default_nettype wire

// ===== rtl/core/credit_balanced_batch_reorderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Push: result strobe in the cycle after the accept;
//   a push can follow every cycle.
// Pop: stack memory read, then credit update, per word; a pop that
//   opens a batch also waits for the 22-step correction divider.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears counts, credit state and batch bookkeeping; batch_size = 64.
// ----------------------------------------------------------------------------
// credit_balanced_batch_reorderer
// Two descriptor stacks (light / heavy) in registered-read memories, popped in
// batches so that the running credit mixes small and large transfers.
// ----------------------------------------------------------------------------
module credit_balanced_batch_reorderer #(
    parameter int unsigned MAX_BATCH = cbbr_pkg::MAX_BATCH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_op,
    input  wire logic [cbbr_pkg::SIZE_W-1:0]       i_xfer_size,
    input  wire logic [cbbr_pkg::TAG_W-1:0]        i_entry_tag,
    // results
    output logic                                   o_strobe,
    output logic [cbbr_pkg::KIND_W-1:0]            o_kind,
    output logic [cbbr_pkg::TAG_W-1:0]             o_out_tag,
    output logic [cbbr_pkg::SIZE_W-1:0]            o_out_size,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cbbr_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int unsigned CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int unsigned ADDR_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH);

    localparam int unsigned LW = cbbr_pkg::LIGHT_W;
    localparam int unsigned HW = cbbr_pkg::HEAVY_W;
    localparam int unsigned SW = cbbr_pkg::SUM_W;
    localparam int unsigned RW = cbbr_pkg::RUN_W;
    localparam int unsigned BW = cbbr_pkg::BATCH_W;

    // control states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // pop source
    localparam logic [1:0] SEL_NONE   = 2'd0;
    localparam logic [1:0] SEL_LIGHT  = 2'd1;
    localparam logic [1:0] SEL_HEAVY  = 2'd2;
    localparam logic [1:0] SEL_LIGHT0 = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                r_sel;
    logic [CNT_W-1:0]          r_light_count;
    logic [CNT_W-1:0]          r_heavy_count;
    logic signed [SW-1:0]      r_credit_sum;
    logic signed [RW-1:0]      r_running;
    logic signed [RW-1:0]      r_correction;
    logic [BW-1:0]             r_pops_left;
    logic [BW-1:0]             r_batch_size;

    logic                          r_strobe;
    logic [cbbr_pkg::KIND_W-1:0]   r_kind;
    logic [cbbr_pkg::TAG_W-1:0]    r_tag;
    logic [cbbr_pkg::SIZE_W-1:0]   r_size;

    logic [LW-1:0]             light_mem [MAX_BATCH];
    logic [HW-1:0]             heavy_mem [MAX_BATCH];
    logic [LW-1:0]             r_light_rd;
    logic [HW-1:0]             r_heavy_rd;

    logic                      w_accept;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_is_light;
    logic                      w_push_ok;
    logic [cbbr_pkg::LCRED_W-1:0] w_light_credit;
    logic [cbbr_pkg::HCRED_W-1:0] w_heavy_credit;
    logic signed [7:0]         w_push_credit;
    logic signed [SW:0]        w_sum_ext;
    logic signed [SW-1:0]      n_credit_sum;
    logic                      w_batch_start;
    logic                      w_run_pos;
    logic [1:0]                n_sel;
    logic [BW-1:0]             w_bs;
    logic [CNT_W-1:0]          w_light_cm1;
    logic [CNT_W-1:0]          w_heavy_cm1;
    logic                      w_light_we;
    logic                      w_heavy_we;
    logic                      w_light_re;
    logic                      w_heavy_re;
    logic signed [7:0]         w_delta;
    logic signed [RW+1:0]      w_run_ext;
    logic signed [RW-1:0]      n_running;
    logic                      w_cfg_we;

    cbbr_pkg::t_div_req        w_div_req;
    logic                      w_div_done;
    logic signed [RW-1:0]      w_div_quot;

    // handshake
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_push   = w_accept && !i_op;
    assign w_pop    = w_accept && i_op;

    // push classification and credit
    assign w_is_light     = (i_xfer_size[cbbr_pkg::SIZE_W-1:cbbr_pkg::LSIZE_W] == '0);
    assign w_light_credit = i_xfer_size[cbbr_pkg::LSIZE_W-1] ? 2'b11 : 2'b10;
    assign w_heavy_credit = cbbr_pkg::heavy_credit(i_xfer_size);
    assign w_push_credit  = w_is_light ? $signed({6'b111111, w_light_credit})
                                       : $signed({1'b0, w_heavy_credit});
    assign w_push_ok      = w_is_light ? (r_light_count != CNT_MAX)
                                       : (r_heavy_count != CNT_MAX);

    // saturating credit sum
    assign w_sum_ext = $signed({r_credit_sum[SW-1], r_credit_sum})
                     + $signed({{(SW-7){w_push_credit[7]}}, w_push_credit});
    always_comb begin
        if (w_sum_ext[SW] != w_sum_ext[SW-1]) begin
            n_credit_sum = w_sum_ext[SW] ? $signed({1'b1, {(SW-1){1'b0}}})
                                         : $signed({1'b0, {(SW-1){1'b1}}});
        end else begin
            n_credit_sum = w_sum_ext[SW-1:0];
        end
    end

    // pop source choice, from the state before this pop
    assign w_batch_start = (r_pops_left == '0);
    assign w_run_pos     = !w_batch_start && (r_running > 0);
    assign w_bs          = (r_batch_size == '0) ? BW'(1) : r_batch_size;

    always_comb begin
        priority if (w_run_pos && r_light_count != '0) begin
            n_sel = SEL_LIGHT;
        end else if (r_heavy_count != '0) begin
            n_sel = SEL_HEAVY;
        end else if (r_light_count != '0) begin
            n_sel = SEL_LIGHT0;
        end else begin
            n_sel = SEL_NONE;
        end
    end

    // stack memory ports
    assign w_light_cm1 = r_light_count - 1'b1;
    assign w_heavy_cm1 = r_heavy_count - 1'b1;
    assign w_light_we  = w_push && w_is_light && w_push_ok;
    assign w_heavy_we  = w_push && !w_is_light && w_push_ok;
    assign w_light_re  = w_pop && (n_sel == SEL_LIGHT || n_sel == SEL_LIGHT0);
    assign w_heavy_re  = w_pop && (n_sel == SEL_HEAVY);

    always_ff @(posedge i_clk) begin
        if (w_light_we) begin
            light_mem[r_light_count[ADDR_W-1:0]] <=
                {i_entry_tag, i_xfer_size[cbbr_pkg::LSIZE_W-1:0], w_light_credit};
        end
        if (w_light_re) begin
            r_light_rd <= light_mem[w_light_cm1[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_heavy_we) begin
            heavy_mem[r_heavy_count[ADDR_W-1:0]] <= {i_entry_tag, i_xfer_size, w_heavy_credit};
        end
        if (w_heavy_re) begin
            r_heavy_rd <= heavy_mem[w_heavy_cm1[ADDR_W-1:0]];
        end
    end

    // credit of the taken entry
    always_comb begin
        unique case (r_sel)
            SEL_LIGHT:  w_delta = $signed({6'b111111, r_light_rd[cbbr_pkg::LCRED_W-1:0]});
            SEL_HEAVY:  w_delta = $signed({1'b0, r_heavy_rd[cbbr_pkg::HCRED_W-1:0]});
            SEL_LIGHT0: w_delta = 8'sd0;
            SEL_NONE:   w_delta = 8'sd0;
            default:    w_delta = 8'sd0;
        endcase
    end

    // saturating running credit update
    assign w_run_ext = $signed({{2{r_running[RW-1]}}, r_running})
                     + $signed({{(RW-14){w_delta[7]}}, w_delta, 8'd0})
                     + $signed({{2{r_correction[RW-1]}}, r_correction});
    always_comb begin
        if (w_run_ext[RW+1:RW-1] != 3'b000 && w_run_ext[RW+1:RW-1] != 3'b111) begin
            n_running = w_run_ext[RW+1] ? $signed({1'b1, {(RW-1){1'b0}}})
                                        : $signed({1'b0, {(RW-1){1'b1}}});
        end else begin
            n_running = w_run_ext[RW-1:0];
        end
    end

    // correction divider
    assign w_div_req.start      = w_pop && w_batch_start;
    assign w_div_req.credit_sum = r_credit_sum;
    assign w_div_req.divisor    = w_bs;

    cbbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // control and bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sel         <= SEL_NONE;
            r_light_count <= '0;
            r_heavy_count <= '0;
            r_credit_sum  <= '0;
            r_running     <= '0;
            r_correction  <= '0;
            r_pops_left   <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_push) begin
                        r_strobe <= 1'b1;
                        if (w_push_ok) begin
                            r_credit_sum <= n_credit_sum;
                            if (w_is_light) r_light_count <= r_light_count + 1'b1;
                            else            r_heavy_count <= r_heavy_count + 1'b1;
                        end
                    end else if (w_pop) begin
                        r_sel <= n_sel;
                        if (n_sel == SEL_LIGHT || n_sel == SEL_LIGHT0) begin
                            r_light_count <= w_light_cm1;
                        end
                        if (n_sel == SEL_HEAVY) begin
                            r_heavy_count <= w_heavy_cm1;
                        end
                        if (w_batch_start) begin
                            r_pops_left  <= w_bs - 1'b1;
                            r_running    <= '0;
                            r_credit_sum <= '0;
                            r_state      <= S_DIV;
                        end else begin
                            r_pops_left <= r_pops_left - 1'b1;
                            r_state     <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_correction <= w_div_quot;
                        r_state      <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_running <= n_running;
                    r_strobe  <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind <= w_push_ok ? cbbr_pkg::KIND_PUSH_OK : cbbr_pkg::KIND_PUSH_OVF;
            r_tag  <= '0;
            r_size <= '0;
        end else if (r_state == S_FIN) begin
            unique case (r_sel)
                SEL_LIGHT, SEL_LIGHT0: begin
                    r_kind <= cbbr_pkg::KIND_POP_OK;
                    r_tag  <= r_light_rd[LW-1 -: cbbr_pkg::TAG_W];
                    r_size <= (cbbr_pkg::SIZE_W)'(
                        r_light_rd[cbbr_pkg::LCRED_W +: cbbr_pkg::LSIZE_W]);
                end
                SEL_HEAVY: begin
                    r_kind <= cbbr_pkg::KIND_POP_OK;
                    r_tag  <= r_heavy_rd[HW-1 -: cbbr_pkg::TAG_W];
                    r_size <= r_heavy_rd[cbbr_pkg::HCRED_W +: cbbr_pkg::SIZE_W];
                end
                default: begin
                    r_kind <= cbbr_pkg::KIND_POP_NONE;
                    r_tag  <= '0;
                    r_size <= '0;
                end
            endcase
        end
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_out_tag  = r_tag;
    assign o_out_size = r_size;

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite
                   && (paddr[cbbr_pkg::PADDR_W-1] == cbbr_pkg::REG_BATCH_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size <= cbbr_pkg::BATCH_RESET;
        end else if (w_cfg_we) begin
            r_batch_size <= pwdata[BW-1:0];
        end
    end

    assign prdata = (paddr[cbbr_pkg::PADDR_W-1] == cbbr_pkg::REG_BATCH_SIZE)
                  ? 32'(r_batch_size) : 32'd0;

    // checks
    a_light_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_light_count <= CNT_MAX)
        else $error("light stack count beyond depth");

    a_heavy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heavy_count <= CNT_MAX)
        else $error("heavy stack count beyond depth");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted word neither answered nor in progress");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_kind != cbbr_pkg::KIND_POP_OK) |-> (o_out_tag == '0 && o_out_size == '0))
        else $error("non-pop result carries payload");

endmodule
`default_nettype wire

// ===== tb/credit_balanced_batch_reorderer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_balanced_batch_reorderer_tb
// Self-checking bench for the batch reorderer. A queued driver issues push
// and pop commands with random gaps and writes batch_size over the config
// port between phases. A monitor predicts every result word from the accepted
// commands and checks it field by field against the strobed output.
// ----------------------------------------------------------------------------
module credit_balanced_batch_reorderer_tb;

    // command codes and register map
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;
    localparam int   REG_SPARE_IDX = 1;
    localparam logic [cbbr_pkg::PADDR_W-1:0] ADDR_BATCH_SIZE =
        cbbr_pkg::PADDR_W'(4 * cbbr_pkg::REG_BATCH_SIZE);
    localparam logic [cbbr_pkg::PADDR_W-1:0] ADDR_SPARE =
        cbbr_pkg::PADDR_W'(4 * REG_SPARE_IDX);

    // stack depth and credit limits
    localparam int MAX_DEPTH   = cbbr_pkg::MAX_BATCH_DEF;
    localparam int LIGHT_LIMIT = 8192;
    localparam int MID_LIMIT   = 4096;
    localparam int SUM_MAX     = 8191;
    localparam int SUM_MIN     = -8192;
    localparam int RUN_MAX     = 8388607;
    localparam int RUN_MIN     = -8388608;

    // run control
    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int QUIET_FROM    = 500;
    localparam int QUIET_TO      = 800;

    typedef enum logic [1:0] {WORK_CMD, WORK_CFG, WORK_DRAIN} t_work_kind;
    typedef enum logic [1:0] {DRV_RUN, DRV_SETTLE, DRV_SETUP, DRV_ACCESS} t_drv_state;

    typedef struct {
        t_work_kind                       kind;
        logic                             op;
        logic [cbbr_pkg::SIZE_W-1:0]      size;
        logic [cbbr_pkg::TAG_W-1:0]       tag;
        logic [cbbr_pkg::PADDR_W-1:0]     addr;
        logic [31:0]                      data;
    } t_work;

    typedef struct packed {
        logic [cbbr_pkg::KIND_W-1:0]      kind;
        logic [cbbr_pkg::TAG_W-1:0]       tag;
        logic [cbbr_pkg::SIZE_W-1:0]      size;
    } t_result;

    // DUT signals
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               start       = 1'b0;
    logic                               busy;
    logic                               i_op        = OP_PUSH;
    logic [cbbr_pkg::SIZE_W-1:0]        i_xfer_size = '0;
    logic [cbbr_pkg::TAG_W-1:0]         i_entry_tag = '0;
    logic                               o_strobe;
    logic [cbbr_pkg::KIND_W-1:0]        o_kind;
    logic [cbbr_pkg::TAG_W-1:0]         o_out_tag;
    logic [cbbr_pkg::SIZE_W-1:0]        o_out_size;
    logic                               psel        = 1'b0;
    logic                               penable     = 1'b0;
    logic                               pwrite      = 1'b0;
    logic [cbbr_pkg::PADDR_W-1:0]       paddr       = '0;
    logic [31:0]                        pwdata      = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    // bench state
    t_work       cmd_backlog[$];
    t_result     due_words[$];
    t_drv_state  drv_state  = DRV_RUN;
    int          settle_cnt = 0;
    int          sent_cnt   = 0;
    int          cycle_cnt  = 0;
    int          mismatches = 0;

    // predictor copy of the stacks and credit bookkeeping
    logic [cbbr_pkg::TAG_W-1:0]   lt_tag  [MAX_DEPTH];
    logic [cbbr_pkg::SIZE_W-1:0]  lt_size [MAX_DEPTH];
    int                           lt_cred [MAX_DEPTH];
    logic [cbbr_pkg::TAG_W-1:0]   hv_tag  [MAX_DEPTH];
    logic [cbbr_pkg::SIZE_W-1:0]  hv_size [MAX_DEPTH];
    int                           hv_cred [MAX_DEPTH];
    int                           lt_cnt     = 0;
    int                           hv_cnt     = 0;
    int                           sum_cred   = 0;
    int                           run_q8     = 0;
    int                           corr_q8    = 0;
    int                           batch_left = 0;
    logic [cbbr_pkg::BATCH_W-1:0] batch_cfg  = cbbr_pkg::BATCH_RESET;

    credit_balanced_batch_reorderer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_xfer_size (i_xfer_size),
        .i_entry_tag (i_entry_tag),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_out_tag   (o_out_tag),
        .o_out_size  (o_out_size),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // heavy credit by index of the highest set bit
    function automatic int heavy_weight(input logic [cbbr_pkg::SIZE_W-1:0] size);
        int msb;
        msb = 0;
        for (int i = 0; i < cbbr_pkg::SIZE_W; i++) begin
            if (size[i]) msb = i;
        end
        case (msb)
            13: return 1;
            14: return 4;
            15, 16, 17: return 8;
            18: return 16;
            19: return 30;
            20: return 35;
            21: return 40;
            22: return 45;
            23: return 50;
            24: return 55;
            25, 26, 27, 28, 29, 30: return 60;
            default: return 0;
        endcase
    endfunction

    // advance the predictor by one command and return its result word
    function automatic t_result reorder_word(input logic op,
                                             input logic [cbbr_pkg::SIZE_W-1:0] size,
                                             input logic [cbbr_pkg::TAG_W-1:0] tag);
        t_result r;
        int      cred;
        int      div;
        r.kind = cbbr_pkg::KIND_PUSH_OK;
        r.tag  = '0;
        r.size = '0;
        cred   = 0;
        if (op == OP_PUSH) begin
            if (size < LIGHT_LIMIT) begin
                if (lt_cnt >= MAX_DEPTH) begin
                    r.kind = cbbr_pkg::KIND_PUSH_OVF;
                end else begin
                    cred = (size >= MID_LIMIT) ? -1 : -2;
                    lt_tag[lt_cnt]  = tag;
                    lt_size[lt_cnt] = size;
                    lt_cred[lt_cnt] = cred;
                    lt_cnt++;
                    sum_cred = clamp_int(sum_cred + cred, SUM_MIN, SUM_MAX);
                end
            end else begin
                if (hv_cnt >= MAX_DEPTH) begin
                    r.kind = cbbr_pkg::KIND_PUSH_OVF;
                end else begin
                    cred = heavy_weight(size);
                    hv_tag[hv_cnt]  = tag;
                    hv_size[hv_cnt] = size;
                    hv_cred[hv_cnt] = cred;
                    hv_cnt++;
                    sum_cred = clamp_int(sum_cred + cred, SUM_MIN, SUM_MAX);
                end
            end
        end else begin
            // batch opens: correction from the credit pushed since last open
            if (batch_left == 0) begin
                div        = (batch_cfg == 0) ? 1 : int'(batch_cfg);
                batch_left = div;
                run_q8     = 0;
                corr_q8    = (-sum_cred * 256) / div;
                sum_cred   = 0;
            end
            batch_left--;
            r.kind = cbbr_pkg::KIND_POP_OK;
            if (run_q8 > 0 && lt_cnt > 0) begin
                lt_cnt--;
                cred   = lt_cred[lt_cnt];
                r.tag  = lt_tag[lt_cnt];
                r.size = lt_size[lt_cnt];
            end else if (hv_cnt > 0) begin
                hv_cnt--;
                cred   = hv_cred[hv_cnt];
                r.tag  = hv_tag[hv_cnt];
                r.size = hv_size[hv_cnt];
            end else if (lt_cnt > 0) begin
                // last resort light entry counts with zero credit
                lt_cnt--;
                r.tag  = lt_tag[lt_cnt];
                r.size = lt_size[lt_cnt];
            end else begin
                r.kind = cbbr_pkg::KIND_POP_NONE;
            end
            run_q8 = clamp_int(run_q8 + cred * 256 + corr_q8, RUN_MIN, RUN_MAX);
        end
        return r;
    endfunction

    // size with its top set bit drawn from [lo_bit, hi_bit]
    function automatic logic [cbbr_pkg::SIZE_W-1:0] any_size(input int lo_bit,
                                                             input int hi_bit);
        int          b;
        logic [31:0] v;
        b = $urandom_range(hi_bit, lo_bit);
        v = $urandom;
        if (b == 0) return v & 32'h1;
        return (32'h1 << b) | (v & ((32'h1 << b) - 32'h1));
    endfunction

    task automatic add_cmd(input logic op, input logic [cbbr_pkg::SIZE_W-1:0] size,
                           input logic [cbbr_pkg::TAG_W-1:0] tag);
        t_work w;
        w = '{kind: WORK_CMD, op: op, size: size, tag: tag, addr: '0, data: '0};
        cmd_backlog.insert(cmd_backlog.size(), w);
    endtask

    task automatic add_cfg(input logic [cbbr_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
        t_work w;
        w = '{kind: WORK_CFG, op: OP_PUSH, size: '0, tag: '0, addr: addr, data: data};
        cmd_backlog.insert(cmd_backlog.size(), w);
    endtask

    task automatic add_drain();
        t_work w;
        w = '{kind: WORK_DRAIN, op: OP_PUSH, size: '0, tag: '0, addr: '0, data: '0};
        cmd_backlog.insert(cmd_backlog.size(), w);
    endtask

    // bursts leaning to pushes, to pops, or balanced
    task automatic mix_phase(input int n);
        int done;
        int burst;
        int pct;
        done = 0;
        while (done < n) begin
            burst = $urandom_range(80, 20);
            case ($urandom_range(2, 0))
                0: pct = 90;
                1: pct = 50;
                default: pct = 20;
            endcase
            if ($urandom_range(5, 0) == 0) add_drain();
            for (int k = 0; k < burst && done < n; k++) begin
                if ($urandom_range(99, 0) < pct) add_cmd(OP_PUSH, any_size(0, 31), $urandom);
                else add_cmd(OP_POP, $urandom, $urandom);
                done++;
            end
        end
    endtask

    // stimulus, then reset release and end of run
    initial begin
        // empty pop, size class edges, then unwind both stacks
        add_cmd(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cmd(OP_PUSH, 32'd0, 32'h0000_0000);
        add_cmd(OP_PUSH, 32'd4095, 32'hFFFF_FFFF);
        add_cmd(OP_PUSH, 32'd4096, 32'h1234_5678);
        add_cmd(OP_PUSH, 32'd8191, 32'h8765_4321);
        add_cmd(OP_PUSH, 32'd8192, 32'hA5A5_A5A5);
        add_cmd(OP_PUSH, 32'd16383, 32'h5A5A_5A5A);
        add_cmd(OP_PUSH, 32'h8000_0000, 32'h0000_0001);
        add_cmd(OP_PUSH, 32'hFFFF_FFFF, 32'h8000_0000);
        add_cmd(OP_PUSH, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        for (int k = 0; k < 10; k++) add_cmd(OP_POP, 32'd0, 32'd0);
        add_drain();

        // write to an unmapped register index must not move batch_size
        add_cfg(ADDR_SPARE, 32'd3);
        mix_phase(60);
        add_cfg(ADDR_BATCH_SIZE, 32'd1);
        mix_phase(200);
        add_cfg(ADDR_BATCH_SIZE, 32'd0);
        mix_phase(150);

        // widest batch: push heavy faster than popping to saturate credit sum
        add_cfg(ADDR_BATCH_SIZE, 32'd127);
        for (int k = 0; k < 130; k++) begin
            add_cmd(OP_PUSH, any_size(25, 30), $urandom);
            add_cmd(OP_PUSH, any_size(25, 30), $urandom);
            add_cmd(OP_POP, $urandom, $urandom);
        end
        mix_phase(120);

        // overfill the light stack
        add_cfg(ADDR_BATCH_SIZE, 32'd3);
        for (int k = 0; k < 70; k++) add_cmd(OP_PUSH, any_size(0, 12), $urandom);
        mix_phase(180);
        add_cfg(ADDR_BATCH_SIZE, 32'd64);
        mix_phase(200);
        add_cfg(ADDR_BATCH_SIZE, 32'd17);
        mix_phase(60);
        add_cfg(ADDR_BATCH_SIZE, 32'd2);
        mix_phase(100);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || due_words.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_words.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, due_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // driver: commands with random gaps, drains and config writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            psel      <= 1'b0;
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            drv_state <= DRV_RUN;
        end else begin
            case (drv_state)
                DRV_RUN: begin
                    if (!(start && busy)) begin
                        if (start) begin
                            void'(cmd_backlog.pop_front());
                            sent_cnt++;
                        end
                        if (cmd_backlog.size() == 0) begin
                            start <= 1'b0;
                        end else if (cmd_backlog[0].kind != WORK_CMD) begin
                            start      <= 1'b0;
                            settle_cnt <= 0;
                            drv_state  <= DRV_SETTLE;
                        end else if (!(sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO)
                                     && $urandom_range(99, 0) < 9) begin
                            start <= 1'b0;
                        end else begin
                            start       <= 1'b1;
                            i_op        <= cmd_backlog[0].op;
                            i_xfer_size <= cmd_backlog[0].size;
                            i_entry_tag <= cmd_backlog[0].tag;
                        end
                    end
                end
                // block must be idle with nothing outstanding
                DRV_SETTLE: begin
                    if (due_words.size() != 0 || busy) begin
                        settle_cnt <= 0;
                    end else if (settle_cnt == SETTLE_CYCLES - 1) begin
                        if (cmd_backlog[0].kind == WORK_DRAIN) begin
                            void'(cmd_backlog.pop_front());
                            drv_state <= DRV_RUN;
                        end else begin
                            psel      <= 1'b1;
                            penable   <= 1'b0;
                            pwrite    <= 1'b1;
                            paddr     <= cmd_backlog[0].addr;
                            pwdata    <= cmd_backlog[0].data;
                            drv_state <= DRV_SETUP;
                        end
                    end else begin
                        settle_cnt <= settle_cnt + 1;
                    end
                end
                DRV_SETUP: begin
                    penable   <= 1'b1;
                    drv_state <= DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    if (pready) begin
                        psel    <= 1'b0;
                        penable <= 1'b0;
                        pwrite  <= 1'b0;
                        void'(cmd_backlog.pop_front());
                        drv_state <= DRV_RUN;
                    end
                end
                default: drv_state <= DRV_RUN;
            endcase
        end
    end

    // monitor: check strobed words, predict accepted commands, track config
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected word kind %0d tag %h size %h",
                             $time, o_kind, o_out_tag, o_out_size);
                    mismatches++;
                end else begin
                    want = due_words.pop_front();
                    if (o_kind !== want.kind) begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, o_kind);
                        mismatches++;
                    end
                    if (o_out_tag !== want.tag) begin
                        $display("%0t: out_tag expected %h actual %h",
                                 $time, want.tag, o_out_tag);
                        mismatches++;
                    end
                    if (o_out_size !== want.size) begin
                        $display("%0t: out_size expected %h actual %h",
                                 $time, want.size, o_out_size);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                due_words.insert(due_words.size(),
                                 reorder_word(i_op, i_xfer_size, i_entry_tag));
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_BATCH_SIZE) begin
                batch_cfg = pwdata[cbbr_pkg::BATCH_W-1:0];
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
